[hdl/rrba_pkg.sv]
package rrba_pkg;

  // Scale factor search: 30 quotient bits, two bits resolved per stage.
  localparam int QUO_BITS = 30;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = QUO_BITS / BITS_PER_STAGE;
  localparam int NUM_CORNERS = 4;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] top;
    logic signed [31:0] right;
    logic signed [31:0] bottom;
    logic [NUM_CORNERS-1:0][30:0] rad;
    logic [15:0] grp;
  } shape_t;

  typedef struct packed {
    logic [32:0] dvsr;
    logic [32:0] rem;
    logic [QUO_BITS-1:0] quo;
    logic need;
    logic fail;
  } div_t;

  // Knot slots in clockwise outline order.
  typedef enum logic [2:0] {
    SLOT_TL_END   = 3'd0,
    SLOT_TR_START = 3'd1,
    SLOT_TR_END   = 3'd2,
    SLOT_BR_START = 3'd3,
    SLOT_BR_END   = 3'd4,
    SLOT_BL_START = 3'd5,
    SLOT_BL_END   = 3'd6,
    SLOT_TL_START = 3'd7
  } slot_e;

  // Restoring division, BITS_PER_STAGE quotient bits.
  function automatic div_t div_stage(input div_t a);
    div_t r;
    logic [33:0] rem2;
    r = a;
    for (int b = 0; b < BITS_PER_STAGE; b++) begin
      rem2 = {r.rem, 1'b0};
      if (rem2 >= {1'b0, r.dvsr}) begin
        r.rem = 33'(rem2 - {1'b0, r.dvsr});
        r.quo = {r.quo[QUO_BITS-2:0], 1'b1};
      end else begin
        r.rem = rem2[32:0];
        r.quo = {r.quo[QUO_BITS-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

[hdl/rounded_rect_bezier_anchors.sv]
// Rounded rectangle outline generator, cubic Bezier knots with kappa handles.
// Registers: input, pair limit, divider, scale, radius, kappa, buffer, output.
// Throughput: one knot per cycle on the output while m_axis_tready is high;
// the knot sequencer reading the shape buffer sets this rate.
// Reset: rst_ni is asynchronous, active low, and clears all valid bits.
module rounded_rect_bezier_anchors #(
  parameter int KAPPA_Q16  = 36195,
  parameter int COORD_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // box_left, box_top, box_right, box_bottom, radius_top_left, radius_top_right,
  // radius_bottom_right, radius_bottom_left (32 bits each), group_in (16 bits).
  input  logic [271:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // knot_x, knot_y, handle_in_x, handle_in_y, handle_out_x, handle_out_y
  // (32 bits each), group_out (16 bits).
  output logic [207:0] m_axis_tdata,
  output logic         m_axis_tlast,   // last_knot
  output logic         m_axis_tuser    // is_smooth
);

  localparam int NDS = rrba_pkg::DIV_STAGES;
  localparam int NC  = rrba_pkg::NUM_CORNERS;
  localparam logic [15:0] KappaW = KAPPA_Q16[15:0];
  localparam logic signed [63:0] CMAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;

  // Coordinates are exact in 35 bits; saturate to the coordinate range and
  // emit the low 32 bits.
  function automatic logic [31:0] sat(input logic signed [34:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > CMAX) w = CMAX;
    if (w < CMIN) w = CMIN;
    return w[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Input stage: negative radii are clamped to zero as the request is taken.
  // ---------------------------------------------------------------------------
  rrba_pkg::shape_t in_shape;
  always_comb begin
    in_shape.left   = s_axis_tdata[31:0];
    in_shape.top    = s_axis_tdata[63:32];
    in_shape.right  = s_axis_tdata[95:64];
    in_shape.bottom = s_axis_tdata[127:96];
    for (int i = 0; i < NC; i++) begin
      in_shape.rad[i] = s_axis_tdata[128+32*i+31] ? 31'd0 : s_axis_tdata[128+32*i +: 31];
    end
    in_shape.grp = s_axis_tdata[271:256];
  end

  logic v0_q, v1_q, vsc_q, vmul_q, vkap_q, hv_q;
  logic rdy0, rdy1, rdy_sc, rdy_mul, rdy_kap, rdy_hold;
  rrba_pkg::shape_t s0_q, s1_q, ssc_q, smul_q, skap_q, hs_q;

  assign rdy0 = !v0_q || rdy1;
  assign s_axis_tready = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid) begin
      s0_q <= in_shape;
    end
  end

  // ---------------------------------------------------------------------------
  // Pair limits. The two width pairs share the extent, so only the larger
  // sum can bind; the same holds for height. That leaves two divisions.
  // ---------------------------------------------------------------------------
  logic [32:0] sum_top, sum_bot, sum_lft, sum_rgt, smax_w, smax_h;
  logic signed [32:0] ext_w, ext_h;
  logic need_w, need_h;
  rrba_pkg::div_t dw_init, dh_init, w1_q, h1_q;

  always_comb begin
    sum_top = 33'(s0_q.rad[0]) + 33'(s0_q.rad[1]);
    sum_bot = 33'(s0_q.rad[3]) + 33'(s0_q.rad[2]);
    sum_lft = 33'(s0_q.rad[0]) + 33'(s0_q.rad[3]);
    sum_rgt = 33'(s0_q.rad[1]) + 33'(s0_q.rad[2]);
    smax_w  = (sum_top > sum_bot) ? sum_top : sum_bot;
    smax_h  = (sum_lft > sum_rgt) ? sum_lft : sum_rgt;
    ext_w   = $signed({s0_q.right[31], s0_q.right}) - $signed({s0_q.left[31], s0_q.left});
    ext_h   = $signed({s0_q.bottom[31], s0_q.bottom}) - $signed({s0_q.top[31], s0_q.top});
    need_w  = (smax_w != 33'd0) && ($signed({1'b0, smax_w}) > $signed({ext_w[32], ext_w}));
    need_h  = (smax_h != 33'd0) && ($signed({1'b0, smax_h}) > $signed({ext_h[32], ext_h}));
    dw_init.dvsr = smax_w;
    dw_init.rem  = ext_w;
    dw_init.quo  = '0;
    dw_init.need = need_w;
    dw_init.fail = need_w && (ext_w[32] || (ext_w == 33'sd0));
    dh_init.dvsr = smax_h;
    dh_init.rem  = ext_h;
    dh_init.quo  = '0;
    dh_init.need = need_h;
    dh_init.fail = need_h && (ext_h[32] || (ext_h == 33'sd0));
  end

  logic drdy [NDS];

  assign rdy1 = !v1_q || drdy[0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= v0_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      s1_q <= s0_q;
      w1_q <= dw_init;
      h1_q <= dh_init;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipelined dividers: extent * 2^30 / sum, two quotient bits per stage.
  // ---------------------------------------------------------------------------
  logic             dv_q [NDS];
  rrba_pkg::shape_t ds_q [NDS];
  rrba_pkg::div_t   dw_q [NDS];
  rrba_pkg::div_t   dh_q [NDS];

  for (genvar k = 0; k < NDS; k++) begin : g_div
    logic             in_v;
    rrba_pkg::shape_t in_s;
    rrba_pkg::div_t   in_w, in_h;
    logic             nx_rdy;
    if (k == 0) begin : g_first
      assign in_v = v1_q;
      assign in_s = s1_q;
      assign in_w = w1_q;
      assign in_h = h1_q;
    end else begin : g_mid
      assign in_v = dv_q[k-1];
      assign in_s = ds_q[k-1];
      assign in_w = dw_q[k-1];
      assign in_h = dh_q[k-1];
    end
    if (k == NDS - 1) begin : g_last
      assign nx_rdy = rdy_sc;
    end else begin : g_next
      assign nx_rdy = drdy[k+1];
    end
    assign drdy[k] = !dv_q[k] || nx_rdy;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (drdy[k]) begin
        dv_q[k] <= in_v;
      end
    end
    always_ff @(posedge clk_i) begin
      if (drdy[k] && in_v) begin
        ds_q[k] <= in_s;
        dw_q[k] <= rrba_pkg::div_stage(in_w);
        dh_q[k] <= rrba_pkg::div_stage(in_h);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Common scale factor: minimum of one and both quotients.
  // ---------------------------------------------------------------------------
  logic [30:0] sw, sh, scale_d, scale_q;
  logic        fail_d, fail_q;

  always_comb begin
    sw      = dw_q[NDS-1].need ? {1'b0, dw_q[NDS-1].quo} : rrba_pkg::ONE_Q30;
    sh      = dh_q[NDS-1].need ? {1'b0, dh_q[NDS-1].quo} : rrba_pkg::ONE_Q30;
    scale_d = (sw < sh) ? sw : sh;
    fail_d  = dw_q[NDS-1].fail || dh_q[NDS-1].fail;
  end

  assign rdy_sc = !vsc_q || rdy_mul;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsc_q <= 1'b0;
    end else if (rdy_sc) begin
      vsc_q <= dv_q[NDS-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy_sc && dv_q[NDS-1]) begin
      ssc_q   <= ds_q[NDS-1];
      scale_q <= scale_d;
      fail_q  <= fail_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Scaled radii, one multiplier per corner.
  // ---------------------------------------------------------------------------
  logic [NC-1:0][30:0] rp_d, rp_q, rk_q;
  logic [61:0] prod [NC];

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      prod[i] = 62'(ssc_q.rad[i]) * 62'(scale_q);
      rp_d[i] = fail_q ? 31'd0 : prod[i][60:30];
    end
  end

  assign rdy_mul = !vmul_q || rdy_kap;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmul_q <= 1'b0;
    end else if (rdy_mul) begin
      vmul_q <= vsc_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy_mul && vsc_q) begin
      smul_q <= ssc_q;
      rp_q   <= rp_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Handle offsets: kappa times radius, rounded half up.
  // ---------------------------------------------------------------------------
  logic [NC-1:0][30:0] k_d, kk_q, hk_q;
  logic [46:0] kprod [NC];

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      kprod[i] = 47'(rp_q[i]) * 47'(KappaW) + 47'd32768;
      k_d[i]   = kprod[i][46:16];
    end
  end

  assign rdy_kap = !vkap_q || rdy_hold;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vkap_q <= 1'b0;
    end else if (rdy_kap) begin
      vkap_q <= vmul_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy_kap && vmul_q) begin
      skap_q <= smul_q;
      rk_q   <= rp_q;
      kk_q   <= k_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Shape buffer and knot sequencer. Slots whose corner has zero radius
  // collapse onto the box corner, so a sharp box is the same walk with the
  // second knot of each corner skipped.
  // ---------------------------------------------------------------------------
  logic [NC-1:0][30:0] hr_q;
  rrba_pkg::slot_e idx_q, idx_d;
  logic [7:0] slot_mask, above;
  logic       is_last, load_out;
  logic [2:0] nxt;

  logic signed [34:0] xl, yt, xr, yb;
  logic signed [34:0] r35 [NC];
  logic signed [34:0] k35 [NC];
  logic signed [34:0] kx, ky, ix, iy, ox, oy;
  logic smooth;

  logic         out_v_q, out_last_q, out_smooth_q;
  logic [207:0] out_data_q;

  assign load_out = hv_q && (!out_v_q || m_axis_tready);
  assign rdy_hold = !hv_q || (load_out && is_last);

  always_comb begin
    slot_mask = {hr_q[0] != 31'd0, hr_q[3] != 31'd0, 1'b1, hr_q[2] != 31'd0,
                 1'b1, hr_q[1] != 31'd0, 1'b1, 1'b1};
    above   = slot_mask & (8'hFE << idx_q);
    is_last = (above == 8'd0);
    nxt     = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (above[j]) nxt = 3'(j);
    end
    idx_d = is_last ? rrba_pkg::SLOT_TL_END : rrba_pkg::slot_e'(nxt);
  end

  always_comb begin
    xl = 35'(hs_q.left);
    yt = 35'(hs_q.top);
    xr = 35'(hs_q.right);
    yb = 35'(hs_q.bottom);
    for (int i = 0; i < NC; i++) begin
      r35[i] = $signed({4'd0, hr_q[i]});
      k35[i] = $signed({4'd0, hk_q[i]});
    end
    unique case (idx_q)
      rrba_pkg::SLOT_TL_END: begin
        kx = xl + r35[0]; ky = yt;
        ix = kx - k35[0]; iy = ky; ox = kx; oy = ky;
        smooth = hr_q[0] != 31'd0;
      end
      rrba_pkg::SLOT_TR_START: begin
        kx = xr - r35[1]; ky = yt;
        ix = kx; iy = ky; ox = kx + k35[1]; oy = ky;
        smooth = hr_q[1] != 31'd0;
      end
      rrba_pkg::SLOT_TR_END: begin
        kx = xr; ky = yt + r35[1];
        ix = kx; iy = ky - k35[1]; ox = kx; oy = ky;
        smooth = hr_q[1] != 31'd0;
      end
      rrba_pkg::SLOT_BR_START: begin
        kx = xr; ky = yb - r35[2];
        ix = kx; iy = ky; ox = kx; oy = ky + k35[2];
        smooth = hr_q[2] != 31'd0;
      end
      rrba_pkg::SLOT_BR_END: begin
        kx = xr - r35[2]; ky = yb;
        ix = kx + k35[2]; iy = ky; ox = kx; oy = ky;
        smooth = hr_q[2] != 31'd0;
      end
      rrba_pkg::SLOT_BL_START: begin
        kx = xl + r35[3]; ky = yb;
        ix = kx; iy = ky; ox = kx - k35[3]; oy = ky;
        smooth = hr_q[3] != 31'd0;
      end
      rrba_pkg::SLOT_BL_END: begin
        kx = xl; ky = yb - r35[3];
        ix = kx; iy = ky + k35[3]; ox = kx; oy = ky;
        smooth = hr_q[3] != 31'd0;
      end
      rrba_pkg::SLOT_TL_START: begin
        kx = xl; ky = yt + r35[0];
        ix = kx; iy = ky; ox = kx; oy = ky - k35[0];
        smooth = hr_q[0] != 31'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q    <= 1'b0;
      idx_q   <= rrba_pkg::SLOT_TL_END;
      out_v_q <= 1'b0;
    end else begin
      if (rdy_hold) hv_q <= vkap_q;
      if (load_out) idx_q <= idx_d;
      if (load_out) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_hold && vkap_q) begin
      hs_q <= skap_q;
      hr_q <= rk_q;
      hk_q <= kk_q;
    end
    if (load_out) begin
      out_data_q   <= {hs_q.grp, sat(oy), sat(ox), sat(iy), sat(ix), sat(ky), sat(kx)};
      out_last_q   <= is_last;
      out_smooth_q <= smooth;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_smooth_q;

`ifndef NO_ASSERTIONS
  // A sharp knot carries both handles on the knot itself.
  a_sharp_handles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      (m_axis_tdata[95:64] == m_axis_tdata[31:0]) &&
      (m_axis_tdata[127:96] == m_axis_tdata[63:32]) &&
      (m_axis_tdata[159:128] == m_axis_tdata[31:0]) &&
      (m_axis_tdata[191:160] == m_axis_tdata[63:32]))
    else $error("sharp knot with a displaced handle");

  // An arc knot moves only one of its two handles.
  a_smooth_one_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      ((m_axis_tdata[95:64] == m_axis_tdata[31:0]) &&
       (m_axis_tdata[127:96] == m_axis_tdata[63:32])) ||
      ((m_axis_tdata[159:128] == m_axis_tdata[31:0]) &&
       (m_axis_tdata[191:160] == m_axis_tdata[63:32])))
    else $error("arc knot with both handles displaced");

  // The sequencer is only part way through an outline while a shape is held.
  a_seq_needs_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != rrba_pkg::SLOT_TL_END) |-> hv_q)
    else $error("knot sequencer running without a buffered shape");
`endif

endmodule
